@@ hw/rtl/binary_morphology_3x3_unit_macros.svh @@
// Assertion macros shared by the binary morphology RTL.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef BINARY_MORPHOLOGY_3X3_UNIT_MACROS_SVH
`define BINARY_MORPHOLOGY_3X3_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bmorph_pkg.sv @@
// Shared constants, register codes and types for the 3x3 binary morphology unit.
// No dependencies; used by binary_morphology_3x3_unit.
package bmorph_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int NUM_BANKS = 4;
  localparam int BANK_W    = 2;

  // Field and register widths
  localparam int PIX_W     = 8;
  localparam int DIM_W     = 12;
  localparam int CFG_W     = 12;
  localparam int REG_IDX_W = 3;
  // Width counter must hold both a 12-bit register value and MAX_WIDTH itself
  localparam int WCNT_W    = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  // Pending count runs up to width + 1
  localparam int PEND_W    = WCNT_W + 1;

  typedef logic [PIX_W-1:0] pix_t;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_WIDTH        = 3'd1,
    REG_HEIGHT       = 3'd2,
    REG_DILATE_TH    = 3'd3,
    REG_ERODE_CEN_TH = 3'd4,
    REG_ERODE_NBR_TH = 3'd5
  } reg_index_t;

  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  // Register reset values
  localparam logic [DIM_W-1:0] RST_WIDTH        = 12'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT       = 12'd480;
  localparam pix_t             RST_DILATE_TH    = 8'd127;
  localparam pix_t             RST_ERODE_CEN_TH = 8'd100;
  localparam pix_t             RST_ERODE_NBR_TH = 8'd127;

  localparam pix_t PIX_BLACK = 8'd0;
  localparam pix_t PIX_WHITE = 8'd255;

  // Per-result control carried from the address stage to the compute stage
  typedef struct packed {
    logic              row_end;
    logic              frame_last;
    logic              top_edge;
    logic              bottom_edge;
    logic              left_edge;
    logic              right_edge;
    logic [BANK_W-1:0] bank_up;
    logic [BANK_W-1:0] bank_mid;
    logic [BANK_W-1:0] bank_dn;
    logic              bypass;
  } win_ctrl_t;

endpackage

@@ hw/rtl/binary_morphology_3x3_unit.sv @@
// 3x3 binary erosion / dilation over a raster pixel stream.
// Depends on bmorph_pkg and binary_morphology_3x3_unit_macros.svh.
//
// Takes one grey pixel per clock and returns one black/white pixel per clock
// once the pipeline is primed, while the result stream is not stalled; results
// trail the input by image_width + 1 pixels, and flush transfers after the last
// pixel of a frame drain the rest. A result passes through the registered
// line-store read and then the window compare into the output register, and
// waits in the address stage while the output is stalled. The line store holds
// four row banks of MAX_WIDTH pixels, each read at two columns per result.
// No clearing pass follows reset: only entries written in the current frame
// take part in the compare. Writing image_width or image_height restarts the frame.

`include "binary_morphology_3x3_unit_macros.svh"

module binary_morphology_3x3_unit (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bmorph_pkg::PIX_W-1:0]     s_axis_tdata,  // [7:0] pixel
  input  logic                             s_axis_tuser,  // [0] flush
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bmorph_pkg::PIX_W-1:0]     m_axis_tdata,  // [7:0] out_pixel
  output logic                             m_axis_tuser,  // [0] row_end
  output logic                             m_axis_tlast,  // frame_last
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [bmorph_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [bmorph_pkg::CFG_W-1:0]     cfg_data
);

  localparam int COL_W  = bmorph_pkg::COL_W;
  localparam int DIM_W  = bmorph_pkg::DIM_W;
  localparam int WCNT_W = bmorph_pkg::WCNT_W;
  localparam int PEND_W = bmorph_pkg::PEND_W;
  localparam int BANK_W = bmorph_pkg::BANK_W;
  localparam int NBANK  = bmorph_pkg::NUM_BANKS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic                      mode;
  logic [DIM_W-1:0]          image_width;
  logic [DIM_W-1:0]          image_height;
  bmorph_pkg::pix_t          dilate_th;
  bmorph_pkg::pix_t          erode_cen_th;
  bmorph_pkg::pix_t          erode_nbr_th;
  logic                      size_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= bmorph_pkg::MODE_DILATE;
      image_width  <= bmorph_pkg::RST_WIDTH;
      image_height <= bmorph_pkg::RST_HEIGHT;
      dilate_th    <= bmorph_pkg::RST_DILATE_TH;
      erode_cen_th <= bmorph_pkg::RST_ERODE_CEN_TH;
      erode_nbr_th <= bmorph_pkg::RST_ERODE_NBR_TH;
    end else if (cfg_we) begin
      case (cfg_index)
        bmorph_pkg::REG_MODE:         mode         <= cfg_data[0];
        bmorph_pkg::REG_WIDTH:        image_width  <= cfg_data[DIM_W-1:0];
        bmorph_pkg::REG_HEIGHT:       image_height <= cfg_data[DIM_W-1:0];
        bmorph_pkg::REG_DILATE_TH:    dilate_th    <= cfg_data[bmorph_pkg::PIX_W-1:0];
        bmorph_pkg::REG_ERODE_CEN_TH: erode_cen_th <= cfg_data[bmorph_pkg::PIX_W-1:0];
        bmorph_pkg::REG_ERODE_NBR_TH: erode_nbr_th <= cfg_data[bmorph_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign size_write = cfg_we && ((cfg_index == bmorph_pkg::REG_WIDTH) ||
                                 (cfg_index == bmorph_pkg::REG_HEIGHT));

  // Effective frame size: zero counts as one, width clamps to the store depth
  logic [WCNT_W-1:0] w_eff;
  logic [DIM_W-1:0]  h_eff;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WCNT_W'(1);
    end else if (WCNT_W'(image_width) > WCNT_W'(bmorph_pkg::MAX_WIDTH)) begin
      w_eff = WCNT_W'(bmorph_pkg::MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(image_width);
    end
    h_eff = (image_height == '0) ? DIM_W'(1) : image_height;
  end

  // ---------------------------------------------------------------------------
  // Stream position counters
  logic [COL_W-1:0]  in_column, in_column_next;
  logic [DIM_W-1:0]  in_row, in_row_next;
  logic [COL_W-1:0]  out_column, out_column_next;
  logic [DIM_W-1:0]  out_row, out_row_next;
  logic [PEND_W-1:0] pend, pend_next;
  logic              frame_in_done, frame_in_done_next;

  logic              s1_valid;
  logic              out_en;
  logic              accept;
  logic              is_flush;
  logic              restart;
  logic              emit;

  logic [COL_W-1:0]  b_ic, b_oc, rd_addr_nxt;
  logic [DIM_W-1:0]  b_ir, b_or;
  logic [PEND_W-1:0] b_pend;
  logic [WCNT_W-1:0] ic_inc, oc_inc;
  logic [DIM_W-1:0]  ir_inc;
  logic              col_wrap, out_wrap, frame_end;
  bmorph_pkg::win_ctrl_t ctrl_in;

  // Output register frees up when empty or taken; address stage then moves on
  assign out_en        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_en;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_flush      = s_axis_tuser;
  // A pixel after a complete frame starts the next one
  assign restart       = !is_flush && frame_in_done;

  always_comb begin
    b_ic   = restart ? '0 : in_column;
    b_ir   = restart ? '0 : in_row;
    b_oc   = restart ? '0 : out_column;
    b_or   = restart ? '0 : out_row;
    b_pend = restart ? '0 : pend;

    ic_inc    = WCNT_W'(b_ic) + WCNT_W'(1);
    col_wrap  = (ic_inc == w_eff);
    ir_inc    = b_ir + DIM_W'(1);
    frame_end = (ir_inc == h_eff);
    oc_inc    = WCNT_W'(b_oc) + WCNT_W'(1);
    out_wrap  = (oc_inc == w_eff);

    // Pixel results fire once width + 1 pixels are pending;
    // flush results fire while the finished frame still has rows to give
    if (is_flush) begin
      emit = frame_in_done && (out_row < h_eff);
    end else begin
      emit = (b_pend == (PEND_W'(w_eff) + PEND_W'(1)));
    end

    // Window control for the result at (b_or, b_oc)
    ctrl_in.row_end     = out_wrap;
    ctrl_in.frame_last  = out_wrap && (b_or == h_eff - DIM_W'(1));
    ctrl_in.top_edge    = (b_or == '0);
    ctrl_in.bottom_edge = (b_or == h_eff - DIM_W'(1));
    ctrl_in.left_edge   = (b_oc == '0);
    ctrl_in.right_edge  = out_wrap;
    ctrl_in.bank_up     = b_or[BANK_W-1:0] - BANK_W'(1);
    ctrl_in.bank_mid    = b_or[BANK_W-1:0];
    ctrl_in.bank_dn     = b_or[BANK_W-1:0] + BANK_W'(1);
    // On a pixel result the incoming pixel is the lower-right window entry
    ctrl_in.bypass      = !is_flush;

    rd_addr_nxt = out_wrap ? b_oc : b_oc + COL_W'(1);

    in_column_next     = in_column;
    in_row_next        = in_row;
    out_column_next    = out_column;
    out_row_next       = out_row;
    pend_next          = pend;
    frame_in_done_next = frame_in_done;

    if (accept) begin
      if (!is_flush) begin
        in_column_next     = col_wrap ? '0 : ic_inc[COL_W-1:0];
        in_row_next        = col_wrap ? ir_inc : b_ir;
        frame_in_done_next = col_wrap && frame_end;
        pend_next          = emit ? b_pend : b_pend + PEND_W'(1);
        out_column_next    = b_oc;
        out_row_next       = b_or;
      end
      if (emit) begin
        out_column_next = out_wrap ? '0 : oc_inc[COL_W-1:0];
        out_row_next    = out_wrap ? b_or + DIM_W'(1) : b_or;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      in_column     <= '0;
      in_row        <= '0;
      out_column    <= '0;
      out_row       <= '0;
      pend          <= '0;
      frame_in_done <= 1'b0;
    end else begin
      in_column     <= in_column_next;
      in_row        <= in_row_next;
      out_column    <= out_column_next;
      out_row       <= out_row_next;
      pend          <= pend_next;
      frame_in_done <= frame_in_done_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one bank per row modulo four, read at the center and next column
  bmorph_pkg::pix_t rd_cen [NBANK];
  bmorph_pkg::pix_t rd_nxt [NBANK];

  for (genvar g = 0; g < NBANK; g++) begin : g_bank
    bmorph_pkg::pix_t line_mem [bmorph_pkg::MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (accept && !is_flush && (b_ir[BANK_W-1:0] == BANK_W'(g))) begin
        line_mem[b_ic] <= s_axis_tdata;
      end
      if (accept && emit) begin
        rd_cen[g] <= line_mem[b_oc];
        rd_nxt[g] <= line_mem[rd_addr_nxt];
      end
    end
  end

  // Address stage register
  bmorph_pkg::win_ctrl_t ctrl_s1;
  bmorph_pkg::pix_t      pix_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (out_en) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      ctrl_s1 <= ctrl_in;
      pix_s1  <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Window assembly and threshold compare
  bmorph_pkg::pix_t col_l [3];   // left column, kept from the previous result
  bmorph_pkg::pix_t col_c [3];
  bmorph_pkg::pix_t col_n [3];
  logic             black;

  always_comb begin
    col_c[0] = rd_cen[ctrl_s1.bank_up];
    col_c[1] = rd_cen[ctrl_s1.bank_mid];
    col_c[2] = rd_cen[ctrl_s1.bank_dn];
    col_n[0] = rd_nxt[ctrl_s1.bank_up];
    col_n[1] = rd_nxt[ctrl_s1.bank_mid];
    col_n[2] = ctrl_s1.bypass ? pix_s1 : rd_nxt[ctrl_s1.bank_dn];
  end

  always_comb begin
    bmorph_pkg::pix_t win [3][3];
    logic             row_ok [3];
    logic             col_ok [3];
    logic             any_dark;
    logic             any_bright;

    row_ok[0] = !ctrl_s1.top_edge;
    row_ok[1] = 1'b1;
    row_ok[2] = !ctrl_s1.bottom_edge;
    col_ok[0] = !ctrl_s1.left_edge;
    col_ok[1] = 1'b1;
    col_ok[2] = !ctrl_s1.right_edge;
    any_dark   = 1'b0;
    any_bright = 1'b0;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = col_l[i];
      win[i][1] = col_c[i];
      win[i][2] = col_n[i];
    end
    // Positions outside the image take no part
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          if (win[i][j] < dilate_th)    any_dark   = 1'b1;
          if (win[i][j] > erode_nbr_th) any_bright = 1'b1;
        end
      end
    end
    if (mode == bmorph_pkg::MODE_ERODE) begin
      black = (col_c[1] < erode_cen_th) && !any_bright;
    end else begin
      black = any_dark;
    end
  end

  // Left column shifts in as the result moves to the output register
  always_ff @(posedge clk) begin
    if (s1_valid && out_en) begin
      col_l <= col_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_en) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_en) begin
      m_axis_tdata <= black ? bmorph_pkg::PIX_BLACK : bmorph_pkg::PIX_WHITE;
      m_axis_tuser <= ctrl_s1.row_end;
      m_axis_tlast <= ctrl_s1.frame_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  `BM_ASSERT_SAME(a_pend_bound, 1'b1, pend <= (PEND_W'(w_eff) + PEND_W'(1)),
    "pending count exceeds width + 1")
  `BM_ASSERT_SAME(a_in_col_range, 1'b1, WCNT_W'(in_column) < w_eff,
    "input column beyond frame width")
  `BM_ASSERT_NEXT(a_early_flush, accept && is_flush && !frame_in_done, !s1_valid,
    "flush before frame end produced a result")
  `BM_ASSERT_SAME(a_binary_out, m_axis_tvalid,
    (m_axis_tdata == bmorph_pkg::PIX_BLACK) || (m_axis_tdata == bmorph_pkg::PIX_WHITE),
    "result pixel is neither black nor white")
  `BM_ASSERT_SAME(a_last_ends_row, m_axis_tvalid && m_axis_tlast, m_axis_tuser,
    "frame end without row end")

endmodule
